### sv/ntc_table_interpolate_temp_core_defines.svh
// ---------------------------------------------------------------------------
// NTC table interpolation core: assertion macros
// Concurrent check wrappers; empty when built for synthesis.
// ---------------------------------------------------------------------------
`ifndef NTC_TABLE_INTERPOLATE_TEMP_CORE_DEFINES_SVH
`define NTC_TABLE_INTERPOLATE_TEMP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define NTCIT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntcit: same-cycle check failed");
`define NTCIT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntcit: next-cycle check failed");
`else
`define NTCIT_ASSERT_IMP(label, ante, cons)
`define NTCIT_ASSERT_NXT(label, ante, cons)
`endif
`endif

### sv/ntcit_pkg.sv
// ---------------------------------------------------------------------------
// NTC table interpolation package
// Field widths, codes, microcode format and the control store.
// ---------------------------------------------------------------------------
`default_nettype none

package ntcit_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int TEMP_W    = 24;
    localparam int STEP_W    = 16;
    localparam int LEVEL_W   = 16;
    localparam int IDX_IN_W  = 6;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = LEVEL_W + STEP_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);
    localparam int PC_W      = 5;

    localparam int IN_RAW_W    = IDX_IN_W + LEVEL_W + LEVEL_W;
    localparam int IN_DATA_W   = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W   = TEMP_W + STATUS_W;
    localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = CFG_IDX_W'(2);

    localparam logic signed [TEMP_W-1:0] BOTTOM_RST = TEMP_W'(-12800);
    localparam logic signed [TEMP_W-1:0] TOP_RST    = TEMP_W'(38400);
    localparam logic [STEP_W-1:0]        STEP_RST   = STEP_W'(1280);

    localparam logic [STATUS_W-1:0] STAT_INTERP = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STAT_BOTTOM = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STAT_TOP    = STATUS_W'(2);

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_CONVERT = 1'b1;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_LAST,
        RD_I,
        RD_IM1,
        RD_IP1
    } rd_sel_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LD_FIRST,
        OP_LD_LAST,
        OP_SCAN,
        OP_LD_HI,
        OP_LD_LO,
        OP_PREP,
        OP_DIV_GO,
        OP_FINISH,
        OP_CLAMP_BOT,
        OP_CLAMP_TOP,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_IDLE,
        C_BOT,
        C_TOP,
        C_SCAN,
        C_DIV,
        C_OUT
    } cond_t;

    typedef struct packed {
        rd_sel_t          rd;
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } uword_t;

    typedef struct packed {
        logic               start;
        logic [PROD_W-1:0]  dividend;
        logic [LEVEL_W-1:0] divisor;
    } div_ctl_t;

    typedef struct packed {
        logic              busy;
        logic [PROD_W-1:0] quot;
    } div_stat_t;

    localparam logic [PC_W-1:0] ST_WAIT   = PC_W'(0);
    localparam logic [PC_W-1:0] ST_RD0    = PC_W'(1);
    localparam logic [PC_W-1:0] ST_RDL    = PC_W'(2);
    localparam logic [PC_W-1:0] ST_LDL    = PC_W'(3);
    localparam logic [PC_W-1:0] ST_CHKB   = PC_W'(4);
    localparam logic [PC_W-1:0] ST_CHKT   = PC_W'(5);
    localparam logic [PC_W-1:0] ST_SCAN   = PC_W'(6);
    localparam logic [PC_W-1:0] ST_BR0    = PC_W'(7);
    localparam logic [PC_W-1:0] ST_BR1    = PC_W'(8);
    localparam logic [PC_W-1:0] ST_BR2    = PC_W'(9);
    localparam logic [PC_W-1:0] ST_PREP   = PC_W'(10);
    localparam logic [PC_W-1:0] ST_DGO    = PC_W'(11);
    localparam logic [PC_W-1:0] ST_DWAIT  = PC_W'(12);
    localparam logic [PC_W-1:0] ST_FIN    = PC_W'(13);
    localparam logic [PC_W-1:0] ST_CLB    = PC_W'(14);
    localparam logic [PC_W-1:0] ST_CLT    = PC_W'(15);
    localparam logic [PC_W-1:0] ST_EMIT   = PC_W'(16);

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            ST_WAIT:  w = '{RD_ZERO, OP_NOP,       C_IDLE, ST_WAIT};
            ST_RD0:   w = '{RD_ZERO, OP_NOP,       C_NEXT, ST_WAIT};
            ST_RDL:   w = '{RD_LAST, OP_LD_FIRST,  C_NEXT, ST_WAIT};
            ST_LDL:   w = '{RD_I,    OP_LD_LAST,   C_NEXT, ST_WAIT};
            ST_CHKB:  w = '{RD_I,    OP_NOP,       C_BOT,  ST_CLB};
            ST_CHKT:  w = '{RD_I,    OP_NOP,       C_TOP,  ST_CLT};
            ST_SCAN:  w = '{RD_IP1,  OP_SCAN,      C_SCAN, ST_BR0};
            ST_BR0:   w = '{RD_I,    OP_NOP,       C_NEXT, ST_WAIT};
            ST_BR1:   w = '{RD_IM1,  OP_LD_HI,     C_NEXT, ST_WAIT};
            ST_BR2:   w = '{RD_I,    OP_LD_LO,     C_NEXT, ST_WAIT};
            ST_PREP:  w = '{RD_I,    OP_PREP,      C_NEXT, ST_WAIT};
            ST_DGO:   w = '{RD_I,    OP_DIV_GO,    C_NEXT, ST_WAIT};
            ST_DWAIT: w = '{RD_I,    OP_NOP,       C_DIV,  ST_WAIT};
            ST_FIN:   w = '{RD_I,    OP_FINISH,    C_JUMP, ST_EMIT};
            ST_CLB:   w = '{RD_ZERO, OP_CLAMP_BOT, C_JUMP, ST_EMIT};
            ST_CLT:   w = '{RD_ZERO, OP_CLAMP_TOP, C_JUMP, ST_EMIT};
            ST_EMIT:  w = '{RD_ZERO, OP_EMIT,      C_OUT,  ST_WAIT};
            default:  w = '{RD_ZERO, OP_NOP,       C_JUMP, ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### sv/ntcit_div.sv
// ---------------------------------------------------------------------------
// NTC table interpolation: serial divider
// Restoring divide, one quotient bit per cycle, of the scaled offset by
// the bracket width.
// ---------------------------------------------------------------------------
`default_nettype none

module ntcit_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ntcit_pkg::div_ctl_t  ctl,
    output ntcit_pkg::div_stat_t stat
);
    import ntcit_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEVEL_W-1:0]   rem_reg, rem_next;
    logic [LEVEL_W-1:0]   dvs_reg, dvs_next;
    logic [PROD_W-1:0]    quot_reg, quot_next;
    logic [LEVEL_W:0]     trial;
    logic [LEVEL_W:0]     diff;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        trial     = {rem_reg, quot_reg[PROD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(PROD_W - 1);
            rem_next  = '0;
            dvs_next  = ctl.divisor;
            quot_next = ctl.dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = diff[LEVEL_W-1:0];
                quot_next = {quot_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[LEVEL_W-1:0];
                quot_next = {quot_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.quot = quot_reg;

endmodule

`default_nettype wire

### sv/ntc_table_interpolate_temp_core.sv
// ---------------------------------------------------------------------------
// NTC thermistor table interpolation core
// Microcoded table search and linear interpolation of ADC samples.
// ---------------------------------------------------------------------------
// Input stream: tuser is the kind (0 writes a level table entry, 1 converts
// a sample). A table write gives no output beat.
// Output stream: one beat per conversion with temperature and range status.
// Configuration: bottom, top and step registers, to be written by the user while idle; the block does not enforce it.
// Path of a conversion, from the input beat to the output beat:
//   clamped sample       bottom check hit, or else top check hit, then clamp and emit
//   interpolated sample  k = 1..TABLE_ENTRIES-2 entries scanned; the scan
//                        reads one entry per cycle from the table memory
//                        port, then the serial divide, finish and emit.
// One conversion is in flight at a time; the next input beat is taken as
// soon as the sequencer is back at its wait step, even while the previous
// result still waits in the output register.
// Reset clears the sequencer and the output valid and loads register
// defaults; the table is undefined until written. A stalled receiver holds
// the output beat and the sequencer waits at its emit step.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ntc_table_interpolate_temp_core_defines.svh"

module ntc_table_interpolate_temp_core #(
    parameter int TABLE_ENTRIES = ntcit_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_index[5:0], entry_value[21:6], adc_sample[37:22], zero pad
    input  logic [ntcit_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // temperature[23:0], range_status[25:24], zero pad
    output logic [ntcit_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [ntcit_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ntcit_pkg::TEMP_W-1:0]       cfg_wdata
);
    import ntcit_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int MUL_W = IDX_W + STEP_W;
    localparam int SUM_W = ((MUL_W > TEMP_W) ? MUL_W : TEMP_W) + 2;
    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] IDX_SCAN_END = IDX_W'(TABLE_ENTRIES - 2);
    localparam logic signed [SUM_W-1:0] T_MAX_S = SUM_W'((2 ** (TEMP_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] T_MIN_S = SUM_W'(-(2 ** (TEMP_W - 1)));

    logic [LEVEL_W-1:0] level_mem [TABLE_ENTRIES];
    logic [LEVEL_W-1:0] rdata_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               mem_we;

    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   im1;
    uword_t             uw;

    logic signed [TEMP_W-1:0] bottom_reg;
    logic signed [TEMP_W-1:0] top_reg;
    logic [STEP_W-1:0]        step_reg;

    logic [LEVEL_W-1:0] adc_reg, first_reg, last_reg, hi_reg, lo_reg, dx_reg, wd_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [TEMP_W-1:0] res_temp_reg;
    logic [STATUS_W-1:0]      res_stat_reg;
    logic                     out_valid_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic [STATUS_W-1:0]      out_stat_reg;

    logic [IDX_IN_W-1:0] in_index;
    logic [LEVEL_W-1:0]  in_value;
    logic [LEVEL_W-1:0]  in_adc;
    logic                in_fire;
    logic                conv_fire;
    logic                out_free;
    logic                falling;
    logic                bot_hit;
    logic                top_hit;
    logic                scan_hit;
    logic                scan_end;
    logic [MUL_W-1:0]    base_prod;
    logic signed [SUM_W-1:0] base_sum;
    logic signed [SUM_W-1:0] t_sum;
    logic signed [TEMP_W-1:0] t_sat;

    div_ctl_t  div_ctl;
    div_stat_t div_stat;

    assign in_index = s_axis_tdata[IDX_IN_W-1:0];
    assign in_value = s_axis_tdata[IDX_IN_W+LEVEL_W-1:IDX_IN_W];
    assign in_adc   = s_axis_tdata[IN_RAW_W-1:IDX_IN_W+LEVEL_W];

    assign uw            = ucode(pc_reg);
    assign s_axis_tready = (pc_reg == ST_WAIT);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign conv_fire     = in_fire && (s_axis_tuser == KIND_CONVERT);
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign wr_addr = IDX_W'(in_index);
    assign mem_we  = in_fire && (s_axis_tuser == KIND_WRITE) &&
                     (int'(in_index) < TABLE_ENTRIES);
    assign im1     = i_reg - 1'b1;

    always_comb
    begin
        unique case (uw.rd)
            RD_ZERO: rd_addr = '0;
            RD_LAST: rd_addr = IDX_LAST;
            RD_I:    rd_addr = i_reg;
            RD_IM1:  rd_addr = im1;
            RD_IP1:  rd_addr = i_reg + 1'b1;
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            level_mem[wr_addr] <= in_value;
        end
        rdata_reg <= level_mem[rd_addr];
    end

    assign falling  = first_reg > last_reg;
    assign bot_hit  = falling ? (adc_reg >= first_reg) : (adc_reg <= first_reg);
    assign top_hit  = falling ? (adc_reg <= last_reg) : (adc_reg >= last_reg);
    assign scan_hit = falling ? (adc_reg >= rdata_reg) : (adc_reg <= rdata_reg);
    assign scan_end = (i_reg == IDX_SCAN_END);

    assign base_prod = MUL_W'(im1) * MUL_W'(step_reg);
    assign base_sum  = SUM_W'(bottom_reg) + SUM_W'($signed({1'b0, base_prod}));
    assign t_sum     = acc_reg + SUM_W'($signed({1'b0, div_stat.quot[STEP_W-1:0]}));

    always_comb
    begin
        if (t_sum > T_MAX_S)
        begin
            t_sat = T_MAX_S[TEMP_W-1:0];
        end
        else if (t_sum < T_MIN_S)
        begin
            t_sat = T_MIN_S[TEMP_W-1:0];
        end
        else
        begin
            t_sat = t_sum[TEMP_W-1:0];
        end
    end

    assign div_ctl.start    = (uw.op == OP_DIV_GO);
    assign div_ctl.dividend = PROD_W'(dx_reg) * PROD_W'(step_reg);
    assign div_ctl.divisor  = wd_reg;

    ntcit_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .stat  (div_stat)
    );

    always_comb
    begin
        unique case (uw.cond)
            C_NEXT:  pc_next = pc_reg + 1'b1;
            C_JUMP:  pc_next = uw.target;
            C_IDLE:  pc_next = conv_fire ? (pc_reg + 1'b1) : uw.target;
            C_BOT:   pc_next = bot_hit ? uw.target : (pc_reg + 1'b1);
            C_TOP:   pc_next = top_hit ? uw.target : (pc_reg + 1'b1);
            C_SCAN:  pc_next = (scan_hit || scan_end) ? uw.target : pc_reg;
            C_DIV:   pc_next = div_stat.busy ? pc_reg : (pc_reg + 1'b1);
            C_OUT:   pc_next = out_free ? uw.target : pc_reg;
            default: pc_next = ST_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_WAIT;
            i_reg         <= IDX_W'(1);
            out_valid_reg <= 1'b0;
            bottom_reg    <= BOTTOM_RST;
            top_reg       <= TOP_RST;
            step_reg      <= STEP_RST;
        end
        else
        begin
            pc_reg <= pc_next;
            if (conv_fire)
            begin
                i_reg <= IDX_W'(1);
            end
            else if ((uw.op == OP_SCAN) && !scan_hit)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if ((uw.op == OP_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BOTTOM: bottom_reg <= cfg_wdata;
                    CFG_TOP:    top_reg    <= cfg_wdata;
                    CFG_STEP:   step_reg   <= cfg_wdata[STEP_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (conv_fire)
        begin
            adc_reg <= in_adc;
        end
        case (uw.op)
            OP_LD_FIRST:  first_reg <= rdata_reg;
            OP_LD_LAST:   last_reg  <= rdata_reg;
            OP_LD_HI:     hi_reg    <= rdata_reg;
            OP_LD_LO:     lo_reg    <= rdata_reg;
            OP_PREP:
            begin
                dx_reg  <= falling ? (lo_reg - adc_reg) : (adc_reg - lo_reg);
                wd_reg  <= falling ? (lo_reg - hi_reg) : (hi_reg - lo_reg);
                acc_reg <= base_sum;
            end
            OP_FINISH:
            begin
                res_temp_reg <= t_sat;
                res_stat_reg <= STAT_INTERP;
            end
            OP_CLAMP_BOT:
            begin
                res_temp_reg <= bottom_reg;
                res_stat_reg <= STAT_BOTTOM;
            end
            OP_CLAMP_TOP:
            begin
                res_temp_reg <= top_reg;
                res_stat_reg <= STAT_TOP;
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_temp_reg <= res_temp_reg;
                    out_stat_reg <= res_stat_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OUT_RAW_W){1'b0}}, out_stat_reg, out_temp_reg};

    `NTCIT_ASSERT_NXT(a_conv_starts, conv_fire, pc_reg == ST_RD0)
    `NTCIT_ASSERT_IMP(a_div_in_wait, div_stat.busy, pc_reg == ST_DWAIT)
    `NTCIT_ASSERT_IMP(a_idx_nonzero, 1'b1, i_reg != '0)
    `NTCIT_ASSERT_NXT(a_emit_valid, (uw.op == OP_EMIT) && out_free, m_axis_tvalid)

endmodule

`default_nettype wire
